[hdl/dpst_pkg.sv]
// Shared types, register indexes and operation codes for the decaying penalty
// score tracker. No dependencies; every other file in hdl/ imports this package.
package dpst_pkg;

  // Default depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  // Configuration port geometry
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Iterative divider width and step counter width
  localparam int unsigned DIV_W     = 32;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_W);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BASE_SCORE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SCORE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SCORE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_QUAR_THRESH   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_INTERVAL = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_PER_STEP = 3'd5;

  // Event kinds on the input channel
  localparam logic [1:0] KIND_PENALTY = 2'd0;
  localparam logic [1:0] KIND_REWARD  = 2'd1;

  // Operation codes after classification
  localparam logic [1:0] OP_NONE = 2'd0;
  localparam logic [1:0] OP_ADD  = 2'd1;
  localparam logic [1:0] OP_SUB  = 2'd2;

  // One classified event waiting in the queue
  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] amount;
    logic [31:0] timestamp;
  } work_item_t;

  // Normalized configuration handed from front to back
  typedef struct packed {
    logic signed [15:0] lo;
    logic signed [15:0] hi;
    logic signed [15:0] base;
    logic signed [15:0] thr;
    logic [15:0]        cap;
    logic [31:0]        interval;
    logic [15:0]        per_step;
    logic               decay_on;
  } score_cfg_t;

  // Divider request and response
  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quotient;
    logic [DIV_W-1:0] remainder;
  } div_rsp_t;

endpackage

[hdl/dpst_front.sv]
// Front end: configuration registers, bound normalization and event
// classification into the work queue. Depends on dpst_pkg.
module dpst_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [dpst_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dpst_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         in_kind,
  input  logic [15:0]                        in_amount,
  input  logic [31:0]                        in_timestamp,
  input  logic                               fifo_full,
  output logic                               push,
  output dpst_pkg::work_item_t               push_item,
  output dpst_pkg::score_cfg_t               score_cfg
);
  import dpst_pkg::*;

  logic signed [15:0] base_r, base_nxt;
  logic signed [15:0] min_r, min_nxt;
  logic signed [15:0] max_r, max_nxt;
  logic signed [15:0] thr_r, thr_nxt;
  logic [31:0]        interval_r, interval_nxt;
  logic [15:0]        per_step_r, per_step_nxt;
  score_cfg_t         norm_r, norm_nxt;

  logic signed [15:0] lo, hi, base_c, thr_c;
  logic signed [16:0] cap_w;
  logic               cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid & cfg_ready;

  // Decode register writes; drop out-of-range indexes
  always_comb begin
    base_nxt     = base_r;
    min_nxt      = min_r;
    max_nxt      = max_r;
    thr_nxt      = thr_r;
    interval_nxt = interval_r;
    per_step_nxt = per_step_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_BASE_SCORE:     base_nxt     = cfg_data[15:0];
        REG_MIN_SCORE:      min_nxt      = cfg_data[15:0];
        REG_MAX_SCORE:      max_nxt      = cfg_data[15:0];
        REG_QUAR_THRESH:    thr_nxt      = cfg_data[15:0];
        REG_DECAY_INTERVAL: interval_nxt = cfg_data[31:0];
        REG_DECAY_PER_STEP: per_step_nxt = cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Normalize bounds: swap min/max, clamp base and threshold into range
  always_comb begin
    lo = (min_r > max_r) ? max_r : min_r;
    hi = (min_r > max_r) ? min_r : max_r;
    if (base_r < lo) begin
      base_c = lo;
    end else if (base_r > hi) begin
      base_c = hi;
    end else begin
      base_c = base_r;
    end
    if (thr_r < lo) begin
      thr_c = lo;
    end else if (thr_r > hi) begin
      thr_c = hi;
    end else begin
      thr_c = thr_r;
    end
    cap_w              = {base_c[15], base_c} - {lo[15], lo};
    norm_nxt.lo        = lo;
    norm_nxt.hi        = hi;
    norm_nxt.base      = base_c;
    norm_nxt.thr       = thr_c;
    norm_nxt.cap       = cap_w[15:0];
    norm_nxt.interval  = interval_r;
    norm_nxt.per_step  = per_step_r;
    norm_nxt.decay_on  = (interval_r != 32'd0) && (per_step_r != 16'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r     <= 16'sd100;
      min_r      <= 16'sd0;
      max_r      <= 16'sd100;
      thr_r      <= 16'sd50;
      interval_r <= 32'd0;
      per_step_r <= 16'd0;
      norm_r     <= '0;
    end else begin
      base_r     <= base_nxt;
      min_r      <= min_nxt;
      max_r      <= max_nxt;
      thr_r      <= thr_nxt;
      interval_r <= interval_nxt;
      per_step_r <= per_step_nxt;
      norm_r     <= norm_nxt;
    end
  end

  assign score_cfg = norm_r;

  // Classify the event; zero amount and unused kinds only run decay
  always_comb begin
    push_item.amount    = in_amount;
    push_item.timestamp = in_timestamp;
    if (in_amount == 16'd0) begin
      push_item.op = OP_NONE;
    end else begin
      unique case (in_kind)
        KIND_PENALTY: push_item.op = OP_ADD;
        KIND_REWARD:  push_item.op = OP_SUB;
        default:      push_item.op = OP_NONE;
      endcase
    end
  end

  assign in_stall = fifo_full;
  assign push     = in_valid & ~fifo_full;

endmodule

[hdl/dpst_fifo.sv]
// Short work queue between front and back, register based.
// Depends on dpst_pkg for the work item type.
module dpst_fifo #(
  parameter int unsigned DEPTH = dpst_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  dpst_pkg::work_item_t push_item,
  input  logic                 pop,
  output dpst_pkg::work_item_t head,
  output logic                 empty,
  output logic                 full
);
  import dpst_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  work_item_t        mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  assign empty = (cnt_r == CNT_W'(0));
  assign full  = (cnt_r == CNT_W'(DEPTH));
  assign head  = mem_r[rd_ptr_r];

  // Advance pointers with wrap at the depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the pushed word
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full) else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty) else $error("queue pop while empty");
  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (cnt_r == $past(cnt_r) + CNT_W'(1)))
    else $error("queue count did not advance on push");
`endif

endmodule

[hdl/dpst_div.sv]
// Restoring divider, one quotient bit per cycle, for elapsed time by interval.
// Depends on dpst_pkg for widths and request/response types.
module dpst_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  dpst_pkg::div_req_t            req,
  input  logic [dpst_pkg::DIV_W-1:0]    divisor,
  output dpst_pkg::div_rsp_t            rsp
);
  import dpst_pkg::*;

  logic [DIV_W-1:0]     rem_r, rem_nxt;
  logic [DIV_W-1:0]     quo_r, quo_nxt;
  logic [DIV_W-1:0]     dvs_r, dvs_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_W:0]       trial;

  assign trial = {rem_r, quo_r[DIV_W-1]} - {1'b0, dvs_r};

  // Shift in one dividend bit and try the subtract
  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
      dvs_nxt  = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[DIV_W]) begin
        rem_nxt = trial[DIV_W-1:0];
        quo_nxt = {quo_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[DIV_W-2:0], quo_r[DIV_W-1]};
        quo_nxt = {quo_r[DIV_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + DIV_CNT_W'(1);
      if (cnt_r == DIV_CNT_W'(DIV_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.busy      = busy_r;
  assign rsp.done      = done_r;
  assign rsp.quotient  = quo_r;
  assign rsp.remainder = rem_r;

endmodule

[hdl/dpst_back.sv]
// Back end: runs decay through the divider, applies penalty or reward and
// holds the result word. Depends on dpst_pkg and dpst_div (via the top level).
module dpst_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dpst_pkg::score_cfg_t  score_cfg,
  input  logic                  fifo_empty,
  input  dpst_pkg::work_item_t  head,
  output logic                  pop,
  output dpst_pkg::div_req_t    div_req,
  input  dpst_pkg::div_rsp_t    div_rsp,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [15:0]    out_current_score,
  output logic [15:0]           out_penalty_total,
  output logic                  out_is_quarantined
);
  import dpst_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_SUB  = 3'd3;
  localparam logic [2:0] S_UPD  = 3'd4;

  logic [2:0]         state_r, state_nxt;
  logic [15:0]        pen_r, pen_nxt;
  logic [31:0]        last_r, last_nxt;
  logic [1:0]         op_r, op_nxt;
  logic [15:0]        amt_r, amt_nxt;
  logic [31:0]        now_r, now_nxt;
  logic [31:0]        steps_r, steps_nxt;
  logic [47:0]        dec_r, dec_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic signed [15:0] score_out_r;
  logic [15:0]        pen_out_r;
  logic               quar_out_r;

  logic               load;
  logic [16:0]        add_w;
  logic [15:0]        pen_upd;
  logic signed [17:0] diff_w, lo_w, hi_w, clamp_w;
  logic signed [15:0] score_w;

  // Apply penalty or reward to the decayed penalty
  always_comb begin
    add_w = {1'b0, pen_r} + {1'b0, amt_r};
    unique case (op_r)
      OP_ADD:  pen_upd = (add_w > {1'b0, score_cfg.cap}) ? score_cfg.cap : add_w[15:0];
      OP_SUB:  pen_upd = (amt_r >= pen_r) ? 16'd0 : pen_r - amt_r;
      default: pen_upd = pen_r;
    endcase
  end

  // Score is base minus penalty, clamped into range
  always_comb begin
    diff_w = {{2{score_cfg.base[15]}}, score_cfg.base} - $signed({2'b00, pen_upd});
    lo_w   = {{2{score_cfg.lo[15]}}, score_cfg.lo};
    hi_w   = {{2{score_cfg.hi[15]}}, score_cfg.hi};
    if (diff_w < lo_w) begin
      clamp_w = lo_w;
    end else if (diff_w > hi_w) begin
      clamp_w = hi_w;
    end else begin
      clamp_w = diff_w;
    end
    score_w = clamp_w[15:0];
  end

  // Sequence one word: decay, multiply, subtract, update
  always_comb begin
    state_nxt        = state_r;
    pen_nxt          = pen_r;
    last_nxt         = last_r;
    op_nxt           = op_r;
    amt_nxt          = amt_r;
    now_nxt          = now_r;
    steps_nxt        = steps_r;
    dec_nxt          = dec_r;
    pop              = 1'b0;
    load             = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = head.timestamp - last_r;
    unique case (state_r)
      S_IDLE: begin
        if (!fifo_empty) begin
          pop     = 1'b1;
          op_nxt  = head.op;
          amt_nxt = head.amount;
          now_nxt = head.timestamp;
          if (last_r == 32'd0) begin
            last_nxt  = head.timestamp;
            state_nxt = S_UPD;
          end else if (score_cfg.decay_on && (head.timestamp > last_r)) begin
            div_req.start = 1'b1;
            state_nxt     = S_DIV;
          end else begin
            state_nxt = S_UPD;
          end
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          if (div_rsp.quotient == 32'd0) begin
            state_nxt = S_UPD;
          end else begin
            steps_nxt = div_rsp.quotient;
            last_nxt  = now_r - div_rsp.remainder;
            state_nxt = S_MUL;
          end
        end
      end
      S_MUL: begin
        dec_nxt   = steps_r * score_cfg.per_step;
        state_nxt = S_SUB;
      end
      S_SUB: begin
        if ((dec_r[47:16] != 32'd0) || (dec_r[15:0] >= pen_r)) begin
          pen_nxt = 16'd0;
        end else begin
          pen_nxt = pen_r - dec_r[15:0];
        end
        state_nxt = S_UPD;
      end
      S_UPD: begin
        if (!out_valid_r || !out_stall) begin
          load      = 1'b1;
          pen_nxt   = pen_upd;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold the result word until taken
  always_comb begin
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pen_r       <= 16'd0;
      last_r      <= 32'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pen_r       <= pen_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    amt_r   <= amt_nxt;
    now_r   <= now_nxt;
    steps_r <= steps_nxt;
    dec_r   <= dec_nxt;
    if (load) begin
      score_out_r <= score_w;
      pen_out_r   <= pen_upd;
      quar_out_r  <= (score_w < score_cfg.thr);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_current_score  = score_out_r;
  assign out_penalty_total  = pen_out_r;
  assign out_is_quarantined = quar_out_r;

`ifndef NO_ASSERTIONS
  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_DIV)) else $error("divider done outside divide state");
  a_upd_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPD && !(out_valid_r && out_stall)) |=> (out_valid_r && state_r == S_IDLE))
    else $error("update did not load result");
  a_idle_pops: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && !fifo_empty) |=> (state_r != S_IDLE))
    else $error("queued word not taken");
  a_pen_match: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> (out_penalty_total == pen_r))
    else $error("reported penalty differs from state");
`endif

endmodule

[hdl/decaying_penalty_score_tracker_top.sv]
// Top level of the decaying penalty score tracker: front, work queue, divider
// and back. Depends on dpst_pkg, dpst_front, dpst_fifo, dpst_div, dpst_back.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-----------------------------------------
//   in_     | input     | in_valid/in_stall  | in_kind, in_amount, in_timestamp
//   out_    | output    | out_valid/out_stall| out_current_score, out_penalty_total,
//           |           |                    | out_is_quarantined
//   cfg_    | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// A word that divides goes from queue head to result in this order: pop, the bit-serial
// divide of elapsed time by the interval, taking the quotient, then multiply,
// subtract and update. Under one whole interval it goes from the quotient to update.
// Words that skip the divide go from pop straight to update. The divider sets the pace.
// Reset is synchronous on rst_n and clears state; no clearing pass is needed.
// The queue absorbs QUEUE_DEPTH words while the back end works or out_stall holds.
module decaying_penalty_score_tracker_top #(
  parameter int unsigned QUEUE_DEPTH = dpst_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [dpst_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dpst_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [1:0]                       in_kind,
  input  logic [15:0]                      in_amount,
  input  logic [31:0]                      in_timestamp,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [15:0]               out_current_score,
  output logic [15:0]                      out_penalty_total,
  output logic                             out_is_quarantined
);
  import dpst_pkg::*;

  score_cfg_t score_cfg;
  work_item_t push_item;
  work_item_t head;
  logic       push;
  logic       pop;
  logic       fifo_empty;
  logic       fifo_full;
  div_req_t   div_req;
  div_rsp_t   div_rsp;

  dpst_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_kind      (in_kind),
    .in_amount    (in_amount),
    .in_timestamp (in_timestamp),
    .fifo_full    (fifo_full),
    .push         (push),
    .push_item    (push_item),
    .score_cfg    (score_cfg)
  );

  dpst_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .empty     (fifo_empty),
    .full      (fifo_full)
  );

  dpst_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (div_req),
    .divisor (score_cfg.interval),
    .rsp     (div_rsp)
  );

  dpst_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .score_cfg          (score_cfg),
    .fifo_empty         (fifo_empty),
    .head               (head),
    .pop                (pop),
    .div_req            (div_req),
    .div_rsp            (div_rsp),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_current_score  (out_current_score),
    .out_penalty_total  (out_penalty_total),
    .out_is_quarantined (out_is_quarantined)
  );

endmodule

[bench/tb.sv]
// Self-checking bench for decaying_penalty_score_tracker_top: directed table, then random phases.
// Predicts each result word in-line, or takes it from the table, and checks the block's output.
// Depends on dpst_pkg and the RTL under hdl/.
`timescale 1ns / 100ps

module tb;
  import dpst_pkg::*;

  // Event kinds the package leaves unnamed
  localparam logic [1:0] KIND_DECAY_ONLY = 2'd2;
  localparam logic [1:0] KIND_UNUSED     = 2'd3;

  // Register indexes past the end of the map; writes there are ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  localparam int HOLD_CYCLES  = 300;
  localparam int PHASES       = 8;
  localparam int PHASE_WORDS  = 68;

  typedef struct packed {
    logic signed [15:0] current_score;
    logic [15:0]        penalty_total;
    logic               is_quarantined;
  } score_word_t;

  // One line of the directed table: a register write or an input word
  typedef struct packed {
    logic                  is_reg;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    logic [1:0]            kind;
    logic [15:0]           amount;
    logic [31:0]           stamp;
    logic                  typed;
    score_word_t           want;
  } plan_row_t;

  logic clk;
  logic rst_n;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic in_valid;
  logic in_stall;
  logic [1:0] in_kind;
  logic [15:0] in_amount;
  logic [31:0] in_timestamp;
  logic out_valid;
  logic out_stall;
  logic signed [15:0] out_current_score;
  logic [15:0] out_penalty_total;
  logic out_is_quarantined;

  // Shadow copy of the configuration and the tracker state
  logic signed [15:0] m_base, m_min, m_max, m_thr;
  logic [31:0] m_ivl;
  logic [15:0] m_per;
  logic [15:0] m_pen;
  logic [31:0] m_last;

  score_word_t score_q[$];
  plan_row_t   plan[$];

  int gap_pct = 34;
  int stall_pct = 34;
  bit hold_req = 1'b0;
  int hold_left = 0;
  int n_bad = 0;
  int n_checked = 0;
  int n_words = 0;
  int n_writes = 0;

  decaying_penalty_score_tracker_top u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_kind            (in_kind),
    .in_amount          (in_amount),
    .in_timestamp       (in_timestamp),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_current_score  (out_current_score),
    .out_penalty_total  (out_penalty_total),
    .out_is_quarantined (out_is_quarantined)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Apply decay, then the penalty or reward; return the score word it yields
  function automatic score_word_t advance_score(input logic [1:0] kind,
                                                input logic [15:0] amount,
                                                input logic [31:0] stamp);
    int lo, hi, base_n, thr_n, cap, nxt, score;
    logic [31:0] elapsed, steps;
    longint unsigned drop;
    score_word_t r;
    lo = m_min;
    hi = m_max;
    if (lo > hi) begin
      nxt = lo;
      lo = hi;
      hi = nxt;
    end
    base_n = (m_base < lo) ? lo : (m_base > hi) ? hi : int'(m_base);
    thr_n  = (m_thr < lo) ? lo : (m_thr > hi) ? hi : int'(m_thr);
    cap = base_n - lo;

    // Disabled decay changes nothing; an unset last time only records the stamp
    if (m_ivl == 0 || m_per == 0 || m_last == 0) begin
      if (m_last == 0) m_last = stamp;
    end else if (stamp > m_last) begin
      elapsed = stamp - m_last;
      steps = elapsed / m_ivl;
      if (steps != 0) begin
        drop = 64'(steps) * 64'(m_per);
        m_pen = (drop >= 64'(m_pen)) ? 16'd0 : m_pen - 16'(drop);
        m_last = m_last + steps * m_ivl;
      end
    end

    if (amount != 0) begin
      if (kind == KIND_PENALTY) begin
        nxt = int'(m_pen) + int'(amount);
        m_pen = (nxt > cap) ? 16'(cap) : 16'(nxt);
      end else if (kind == KIND_REWARD) begin
        m_pen = (amount >= m_pen) ? 16'd0 : m_pen - amount;
      end
    end

    score = base_n - int'(m_pen);
    score = (score < lo) ? lo : (score > hi) ? hi : score;
    r.current_score = 16'(score);
    r.penalty_total = m_pen;
    r.is_quarantined = (score < thr_n);
    return r;
  endfunction

  function automatic plan_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] data);
    plan_row_t r;
    r = '0;
    r.is_reg = 1'b1;
    r.idx = idx;
    r.data = data;
    return r;
  endfunction

  function automatic plan_row_t word_row(input logic [1:0] kind, input logic [15:0] amount,
                                         input logic [31:0] stamp, input logic typed,
                                         input score_word_t want);
    plan_row_t r;
    r = '0;
    r.kind = kind;
    r.amount = amount;
    r.stamp = stamp;
    r.typed = typed;
    r.want = want;
    return r;
  endfunction

  // Offer one word after a random gap; predict it once it is taken
  task automatic send_word(input logic [1:0] kind, input logic [15:0] amount,
                           input logic [31:0] stamp, input logic typed,
                           input score_word_t want);
    score_word_t pred;
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_amount <= amount;
    in_timestamp <= stamp;
    do @(posedge clk); while (in_stall !== 1'b0);
    pred = advance_score(kind, amount, stamp);
    score_q.push_back(typed ? want : pred);
    n_words++;
  endtask

  // Hold cfg_valid high; the caller drops it after the last write of a batch
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      REG_BASE_SCORE:     m_base = data[15:0];
      REG_MIN_SCORE:      m_min = data[15:0];
      REG_MAX_SCORE:      m_max = data[15:0];
      REG_QUAR_THRESH:    m_thr = data[15:0];
      REG_DECAY_INTERVAL: m_ivl = data;
      REG_DECAY_PER_STEP: m_per = data[15:0];
      default: ;
    endcase
    n_writes++;
  endtask

  // Stop offering and wait until every predicted word has come back
  task automatic drain_words();
    in_valid <= 1'b0;
    while (score_q.size() != 0) @(posedge clk);
  endtask

  // Pick a full register setting for one random phase
  task automatic set_phase(input int ph);
    logic [15:0] lo_v, hi_v, base_v, thr_v, per_v, tmp;
    logic [31:0] ivl_v;
    if (ph == 3) begin
      lo_v = 16'h8000;
      hi_v = 16'h7FFF;
      base_v = 16'h7FFF;
      thr_v = 16'h0000;
    end else if (ph == 2 || ph == 6) begin
      lo_v = 16'($urandom);
      hi_v = 16'($urandom);
      base_v = 16'($urandom);
      thr_v = 16'($urandom);
    end else begin
      lo_v = 16'(-int'($urandom_range(0, 100)));
      hi_v = 16'($urandom_range(50, 300));
      base_v = 16'(int'($urandom_range(0, 340)) - 120);
      thr_v = 16'(int'($urandom_range(0, 340)) - 120);
      if ($urandom_range(0, 3) == 0) begin
        tmp = lo_v;
        lo_v = hi_v;
        hi_v = tmp;
      end
    end
    case (ph)
      0: begin ivl_v = $urandom_range(1, 20);     per_v = 16'($urandom_range(1, 10)); end
      1: begin ivl_v = $urandom_range(100, 5000); per_v = 16'($urandom_range(1, 50)); end
      2: begin ivl_v = $urandom;                  per_v = 16'($urandom); end
      3: begin ivl_v = 32'hFFFF_FFFF;             per_v = 16'hFFFF; end
      4: begin ivl_v = 32'd0;                     per_v = 16'($urandom_range(1, 20)); end
      5: begin ivl_v = $urandom_range(1, 20);     per_v = 16'd0; end
      6: begin ivl_v = 32'd1;                     per_v = 16'd1; end
      default: begin ivl_v = $urandom_range(1, 20); per_v = 16'hFFFF; end
    endcase
    write_reg(REG_BASE_SCORE, {16'($urandom), base_v});
    write_reg(REG_MIN_SCORE, {16'($urandom), lo_v});
    write_reg(REG_MAX_SCORE, {16'($urandom), hi_v});
    write_reg(REG_QUAR_THRESH, {16'($urandom), thr_v});
    write_reg(REG_DECAY_INTERVAL, ivl_v);
    write_reg(REG_DECAY_PER_STEP, {16'($urandom), per_v});
    write_reg(ph[0] ? REG_SPARE_B : REG_SPARE_A, $urandom);
    cfg_valid <= 1'b0;
  endtask

  // Receiver: random stalls, or a long hold when one is requested
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // Compare each taken result word with the oldest prediction
  always @(posedge clk) begin : check_results
    score_word_t w;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (score_q.size() == 0) begin
        n_bad++;
        if (n_bad <= 10)
          $display("unexpected result word: score %0d penalty %0d quarantine %0b",
                   out_current_score, out_penalty_total, out_is_quarantined);
      end else begin
        w = score_q.pop_front();
        n_checked++;
        if (out_current_score !== w.current_score || out_penalty_total !== w.penalty_total ||
            out_is_quarantined !== w.is_quarantined) begin
          n_bad++;
          if (n_bad <= 10)
            $display("result %0d mismatch: expected score %0d penalty %0d quarantine %0b, got %0d %0d %0b",
                     n_checked, w.current_score, w.penalty_total, w.is_quarantined,
                     out_current_score, out_penalty_total, out_is_quarantined);
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    plan_row_t row;
    bit cfg_open;
    logic [1:0] kind;
    logic [15:0] amount;
    logic [31:0] stamp, delta;
    int pick;

    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_kind = '0;
    in_amount = '0;
    in_timestamp = '0;
    m_base = 16'sd100;
    m_min = 16'sd0;
    m_max = 16'sd100;
    m_thr = 16'sd50;
    m_ivl = '0;
    m_per = '0;
    m_pen = '0;
    m_last = '0;
    cfg_open = 1'b0;

    // Reset settings, decay off: plain adds, cap, rewards, ignored kinds
    plan.push_back(word_row(KIND_PENALTY, 16'd10, 32'd0, 1'b1, '{16'sd90, 16'd10, 1'b0}));
    plan.push_back(reg_row(REG_DECAY_INTERVAL, 32'd10));
    plan.push_back(word_row(KIND_PENALTY, 16'hFFFF, 32'd0, 1'b1, '{16'sd0, 16'd100, 1'b1}));
    plan.push_back(word_row(KIND_REWARD, 16'hFFFF, 32'd0, 1'b1, '{16'sd100, 16'd0, 1'b0}));
    plan.push_back(word_row(KIND_DECAY_ONLY, 16'hFFFF, 32'd0, 1'b1, '{16'sd100, 16'd0, 1'b0}));
    plan.push_back(word_row(KIND_PENALTY, 16'd50, 32'd0, 1'b1, '{16'sd50, 16'd50, 1'b0}));
    plan.push_back(word_row(KIND_PENALTY, 16'd1, 32'd0, 1'b1, '{16'sd49, 16'd51, 1'b1}));
    plan.push_back(word_row(KIND_REWARD, 16'd0, 32'd0, 1'b1, '{16'sd49, 16'd51, 1'b1}));
    plan.push_back(word_row(KIND_UNUSED, 16'd55, 32'd0, 1'b1, '{16'sd49, 16'd51, 1'b1}));
    // Decay on: unset last time, stale stamp, less than one interval, then real decay
    plan.push_back(reg_row(REG_DECAY_PER_STEP, 32'd3));
    plan.push_back(word_row(KIND_DECAY_ONLY, 16'd0, 32'd5, 1'b1, '{16'sd49, 16'd51, 1'b1}));
    plan.push_back(word_row(KIND_DECAY_ONLY, 16'd0, 32'd4, 1'b1, '{16'sd49, 16'd51, 1'b1}));
    plan.push_back(word_row(KIND_DECAY_ONLY, 16'd0, 32'd14, 1'b1, '{16'sd49, 16'd51, 1'b1}));
    plan.push_back(word_row(KIND_REWARD, 16'd0, 32'd35, 1'b0, '0));
    // Huge decay product floors the penalty at zero
    plan.push_back(reg_row(REG_DECAY_PER_STEP, 32'h0000_FFFF));
    plan.push_back(reg_row(REG_DECAY_INTERVAL, 32'd1));
    plan.push_back(word_row(KIND_DECAY_ONLY, 16'd0, 32'h8000_0000, 1'b0, '0));
    plan.push_back(word_row(KIND_PENALTY, 16'hFFFF, 32'h8000_0000, 1'b0, '0));
    // Lowered base pulls a high penalty down to the new cap
    plan.push_back(reg_row(REG_BASE_SCORE, 32'd20));
    plan.push_back(word_row(KIND_PENALTY, 16'd1, 32'h8000_0000, 1'b0, '0));
    // Swapped full-range bounds
    plan.push_back(reg_row(REG_MIN_SCORE, 32'hA5A5_7FFF));
    plan.push_back(reg_row(REG_MAX_SCORE, 32'h5A5A_8000));
    plan.push_back(word_row(KIND_PENALTY, 16'hFFFF, 32'h8000_0000, 1'b0, '0));
    plan.push_back(reg_row(REG_BASE_SCORE, 32'hFFFF_8000));
    plan.push_back(word_row(KIND_PENALTY, 16'd5, 32'h8000_0000, 1'b0, '0));
    plan.push_back(reg_row(REG_QUAR_THRESH, 32'h0000_8000));
    plan.push_back(word_row(KIND_PENALTY, 16'd7, 32'h8000_0000, 1'b0, '0));
    plan.push_back(reg_row(REG_QUAR_THRESH, 32'hFFFF_7FFF));
    plan.push_back(reg_row(REG_BASE_SCORE, 32'h0000_7FFF));
    plan.push_back(reg_row(REG_SPARE_A, 32'hFFFF_FFFF));
    plan.push_back(reg_row(REG_SPARE_B, 32'h1234_5678));
    plan.push_back(word_row(KIND_PENALTY, 16'hFFFF, 32'h8000_0000, 1'b0, '0));
    plan.push_back(reg_row(REG_DECAY_INTERVAL, 32'hFFFF_FFFF));
    plan.push_back(word_row(KIND_REWARD, 16'd1, 32'hFFFF_FFFF, 1'b0, '0));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Walk the directed table; drain before each batch of register writes
    foreach (plan[i]) begin
      row = plan[i];
      if (row.is_reg) begin
        if (!cfg_open) drain_words();
        write_reg(row.idx, row.data);
        cfg_open = 1'b1;
      end else begin
        if (cfg_open) cfg_valid <= 1'b0;
        cfg_open = 1'b0;
        send_word(row.kind, row.amount, row.stamp, row.typed, row.want);
      end
    end

    // Random phases: new settings, then mostly stamps that walk forward by intervals
    for (int ph = 0; ph < PHASES; ph++) begin
      drain_words();
      set_phase(ph);
      gap_pct = (ph == 1) ? 0 : 34;
      stall_pct = (ph == 1) ? 0 : 34;
      if (ph == 2) hold_req = 1'b1;
      for (int n = 0; n < PHASE_WORDS; n++) begin
        pick = $urandom_range(0, 99);
        kind = (pick < 42) ? KIND_PENALTY : (pick < 84) ? KIND_REWARD :
               (pick < 96) ? KIND_DECAY_ONLY : KIND_UNUSED;
        case ($urandom_range(0, 9))
          0: amount = 16'd0;
          1: amount = 16'hFFFF;
          2: amount = 16'($urandom);
          default: amount = 16'($urandom_range(1, 60));
        endcase
        if (m_ivl == 0)
          delta = $urandom_range(0, 1000);
        else if (m_ivl <= 32'h0001_0000)
          delta = m_ivl * $urandom_range(0, 4) + $urandom_range(0, m_ivl - 1);
        else
          delta = m_ivl * $urandom_range(0, 1) + $urandom_range(0, 1000);
        case ($urandom_range(0, 39))
          0: stamp = $urandom;
          1: stamp = '0;
          2, 3: stamp = m_last - $urandom_range(0, 20);
          default: stamp = m_last + delta;
        endcase
        send_word(kind, amount, stamp, 1'b0, '0);
      end
    end

    drain_words();
    repeat (40) @(posedge clk);
    $display("Covered %0d words and %0d register writes over %0d random settings;",
             n_words, n_writes, PHASES);
    $display("%0d result words checked, including a %0d-cycle receiver hold, %0d mismatches.",
             n_checked, HOLD_CYCLES, n_bad);
    if (n_bad == 0 && score_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
